### rtl/assert_macros.svh
// Assertion macros shared by the seek scheduler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define DHSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seek scheduler check failed");

// Antecedent implies consequent in the next cycle
`define DHSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seek scheduler check failed");

`else

`define DHSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DHSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dhss_pkg.sv
// Shared constants, codes and control/status types for the seek scheduler.
// No dependencies; used by the controller, the datapath and the top level.
package dhss_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int RES_W        = $clog2(MAX_REQUESTS + 4);

    localparam int CYL_W     = 16;
    localparam int SUM_W     = 22;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_W     = 40;

    // Scheduling policies
    localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd2;

    localparam logic [MODE_W-1:0] RST_MODE      = MODE_FCFS;
    localparam logic [CYL_W-1:0]  RST_CYL_COUNT = 16'd200;
    localparam logic [CYL_W-1:0]  RST_START     = 16'd0;

    // Which requests a selection pass considers
    typedef enum logic [1:0] {
        PH_NEAR = 2'd0,   // nearest to head, any track
        PH_EQ   = 2'd1,   // on the start cylinder
        PH_UP   = 2'd2,   // above the start cylinder
        PH_DN   = 2'd3    // below the start cylinder
    } t_phase;

    // Where an emitted visit takes its cylinder from
    typedef enum logic [2:0] {
        SRC_START = 3'd0,
        SRC_RAM   = 3'd1,
        SRC_BEST  = 3'd2,
        SRC_LAST  = 3'd3,
        SRC_ZERO  = 3'd4
    } t_src;

    typedef struct packed {
        logic   load;      // request transfer accepted
        logic   idx_clr;   // restart scan index, drop pass winner
        logic   idx_inc;   // advance scan index
        logic   rd;        // compare entry read this cycle
        logic   emit;      // produce one visit
        t_src   src;
        logic   mark;      // mark pass winner served
        logic   finish;    // end of batch
        t_phase phase;
        logic   desc;      // descending order in current pass
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              idx_last;
        logic              found;
        logic              fin_sent;
    } t_sts;

endpackage

### rtl/dhss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dhss_ctrl.sv
// Sequencer for the seek scheduler: loading, selection passes and visit emission.
// Depends on dhss_pkg and assert_macros.svh; drives the datapath by t_cmd.
`include "assert_macros.svh"

module dhss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_last,
    output logic          o_s_ready,
    input  dhss_pkg::t_sts i_sts,
    output dhss_pkg::t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_START  = 11'b00000000010,
        S_F_RD   = 11'b00000000100,
        S_F_EMIT = 11'b00000001000,
        S_PASS   = 11'b00000010000,
        S_WAIT   = 11'b00000100000,
        S_DECIDE = 11'b00001000000,
        S_PICK   = 11'b00010000000,
        S_END    = 11'b00100000000,
        S_ZERO   = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } t_state;

    t_state           r_state, n_state;
    dhss_pkg::t_phase r_phase, n_phase;

    logic sweep_to_end;
    logic circular;
    logic desc_dn;

    assign sweep_to_end = (i_sts.mode == dhss_pkg::MODE_SCAN) ||
                          (i_sts.mode == dhss_pkg::MODE_CSCAN);
    assign circular     = (i_sts.mode == dhss_pkg::MODE_CSCAN);
    assign desc_dn      = (i_sts.mode == dhss_pkg::MODE_SCAN) ||
                          (i_sts.mode == dhss_pkg::MODE_LOOK);

    // State and phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= dhss_pkg::PH_NEAR;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        o_s_ready     = 1'b0;
        o_cmd         = '0;
        o_cmd.src     = dhss_pkg::SRC_START;
        o_cmd.phase   = r_phase;
        o_cmd.desc    = (r_phase == dhss_pkg::PH_DN) && desc_dn;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_s_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = dhss_pkg::SRC_START;
                    o_cmd.idx_clr = 1'b1;
                    unique case (i_sts.mode) inside
                        dhss_pkg::MODE_SSTF: begin
                            n_phase = dhss_pkg::PH_NEAR;
                            n_state = S_PASS;
                        end
                        dhss_pkg::MODE_SCAN, dhss_pkg::MODE_CSCAN,
                        dhss_pkg::MODE_LOOK, dhss_pkg::MODE_CLOOK: begin
                            n_phase = dhss_pkg::PH_EQ;
                            n_state = S_PASS;
                        end
                        default: n_state = S_F_RD;
                    endcase
                end
            end
            // Arrival order: read one entry, then emit it
            S_F_RD: n_state = S_F_EMIT;
            S_F_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = dhss_pkg::SRC_RAM;
                    if (i_sts.idx_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_F_RD;
                    end
                end
            end
            // Selection pass over the store, one entry a cycle
            S_PASS: begin
                o_cmd.rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_WAIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_WAIT: n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_sts.found) begin
                    n_state = S_PICK;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    unique case (r_phase)
                        dhss_pkg::PH_EQ: begin
                            n_phase = dhss_pkg::PH_UP;
                            n_state = S_PASS;
                        end
                        dhss_pkg::PH_UP: begin
                            if (sweep_to_end) begin
                                n_state = S_END;
                            end else begin
                                n_phase = dhss_pkg::PH_DN;
                                n_state = S_PASS;
                            end
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_PICK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = dhss_pkg::SRC_BEST;
                    o_cmd.mark    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_PASS;
                end
            end
            // Move to the last cylinder
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = dhss_pkg::SRC_LAST;
                    if (circular) begin
                        n_state = S_ZERO;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_phase       = dhss_pkg::PH_DN;
                        n_state       = S_PASS;
                    end
                end
            end
            // Wrap to cylinder zero
            S_ZERO: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = dhss_pkg::SRC_ZERO;
                    o_cmd.idx_clr = 1'b1;
                    n_phase       = dhss_pkg::PH_DN;
                    n_state       = S_PASS;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `DHSS_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)
    `DHSS_ASSERT_IMP(a_mark_found, i_clk, i_rst_n, o_cmd.mark, i_sts.found)
    `DHSS_ASSERT_IMP(a_finish_final, i_clk, i_rst_n, r_state == S_FINISH, i_sts.fin_sent)
    `DHSS_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, o_cmd.load && i_s_last, r_state == S_START)

endmodule

### rtl/dhss_dp.sv
// Datapath: config registers, request store, served marks, pass compare,
// seek accounting and the output register. Depends on dhss_pkg and dhss_ram.
module dhss_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_valid,
    input  logic [dhss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dhss_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // request payload
    input  logic [dhss_pkg::CYL_W-1:0]        i_track,
    // result stream
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic [dhss_pkg::CYL_W-1:0]        o_visit,
    output logic [dhss_pkg::SUM_W-1:0]        o_seek,
    output logic                              o_final,
    // control
    input  dhss_pkg::t_cmd                    i_cmd,
    output dhss_pkg::t_sts                    o_sts
);
    localparam int CYL_W = dhss_pkg::CYL_W;
    localparam int SUM_W = dhss_pkg::SUM_W;
    localparam int IDX_W = dhss_pkg::IDX_W;
    localparam int CNT_W = dhss_pkg::CNT_W;
    localparam int RES_W = dhss_pkg::RES_W;
    localparam int MAXR  = dhss_pkg::MAX_REQUESTS;

    logic [dhss_pkg::MODE_W-1:0] r_mode;
    logic [CYL_W-1:0]            r_cyl_count;
    logic [CYL_W-1:0]            r_start;
    logic [CNT_W-1:0]            r_count;
    logic [MAXR-1:0]             r_mark;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_cmp_vld;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic                        r_found;
    logic [CYL_W-1:0]            r_best_key;
    logic [IDX_W-1:0]            r_best_idx;
    logic [CYL_W-1:0]            r_best_val;
    logic [CYL_W-1:0]            r_h0;
    logic [CYL_W-1:0]            r_head;
    logic [SUM_W-1:0]            r_sum;
    logic [RES_W-1:0]            r_res_cnt;
    logic                        r_fin_sent;
    logic                        r_out_vld;
    logic [CYL_W-1:0]            r_out_cyl;
    logic [SUM_W-1:0]            r_out_sum;
    logic                        r_out_last;

    logic [CYL_W-1:0] last_cyl;
    logic [CYL_W-1:0] track_sat;
    logic [CYL_W-1:0] h0_calc;
    logic             store_we;
    logic [CYL_W-1:0] ram_rdata;
    logic             out_free;

    // Last cylinder and saturation
    assign last_cyl  = (r_cyl_count == '0) ? '0 : r_cyl_count - CYL_W'(1);
    assign track_sat = (i_track > last_cyl) ? last_cyl : i_track;
    assign h0_calc   = (r_start > last_cyl) ? last_cyl : r_start;
    assign store_we  = i_cmd.load && (r_count < CNT_W'(MAXR));
    assign out_free  = !r_out_vld || i_m_ready;

    dhss_ram #(
        .WIDTH (CYL_W),
        .DEPTH (MAXR)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (track_sat),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Pass compare on the entry read last cycle
    logic [CYL_W-1:0] diff;
    logic [CYL_W-1:0] key;
    logic             in_rng;
    logic             take;

    always_comb begin
        diff = (ram_rdata > r_head) ? ram_rdata - r_head : r_head - ram_rdata;
        if (i_cmd.phase == dhss_pkg::PH_NEAR) begin
            key = diff;
        end else if (i_cmd.desc) begin
            key = ~ram_rdata;
        end else begin
            key = ram_rdata;
        end
        unique case (i_cmd.phase)
            dhss_pkg::PH_NEAR: in_rng = 1'b1;
            dhss_pkg::PH_EQ:   in_rng = (ram_rdata == r_h0);
            dhss_pkg::PH_UP:   in_rng = (ram_rdata > r_h0);
            dhss_pkg::PH_DN:   in_rng = (ram_rdata < r_h0);
            default:           in_rng = 1'b0;
        endcase
        take = r_cmp_vld && !r_mark[r_cmp_idx] && in_rng &&
               (!r_found || (key < r_best_key));
    end

    // Visit source, distance and final flag
    logic [CYL_W-1:0] emit_cyl;
    logic [CYL_W-1:0] head_ref;
    logic [CYL_W-1:0] emit_d;
    logic [SUM_W-1:0] sum_new;
    logic [RES_W-1:0] cnt_now;
    logic [RES_W-1:0] total_m1;
    logic             emit_final;

    always_comb begin
        case (i_cmd.src)
            dhss_pkg::SRC_START: emit_cyl = h0_calc;
            dhss_pkg::SRC_RAM:   emit_cyl = ram_rdata;
            dhss_pkg::SRC_BEST:  emit_cyl = r_best_val;
            dhss_pkg::SRC_LAST:  emit_cyl = last_cyl;
            default:             emit_cyl = '0;
        endcase
        head_ref = (i_cmd.src == dhss_pkg::SRC_START) ? h0_calc : r_head;
        emit_d   = (emit_cyl > head_ref) ? emit_cyl - head_ref : head_ref - emit_cyl;
        sum_new  = (i_cmd.src == dhss_pkg::SRC_START) ? '0
                                                      : r_sum + SUM_W'(emit_d);
        cnt_now  = (i_cmd.src == dhss_pkg::SRC_START) ? '0 : r_res_cnt;
        case (r_mode)
            dhss_pkg::MODE_SCAN:  total_m1 = RES_W'(r_count) + RES_W'(1);
            dhss_pkg::MODE_CSCAN: total_m1 = RES_W'(r_count) + RES_W'(2);
            default:              total_m1 = RES_W'(r_count);
        endcase
        emit_final = (cnt_now == total_m1);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= dhss_pkg::RST_MODE;
            r_cyl_count <= dhss_pkg::RST_CYL_COUNT;
            r_start     <= dhss_pkg::RST_START;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dhss_pkg::CFG_MODE:      r_mode      <= i_cfg_data[dhss_pkg::MODE_W-1:0];
                dhss_pkg::CFG_CYL_COUNT: r_cyl_count <= i_cfg_data;
                dhss_pkg::CFG_START:     r_start     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state: fill count, marks, scan pipeline, accounting, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_mark     <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_res_cnt  <= '0;
            r_fin_sent <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (store_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_cmp_vld <= i_cmd.rd;
            if (i_cmd.idx_clr) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.mark) begin
                r_mark[r_best_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_res_cnt  <= cnt_now + RES_W'(1);
                r_fin_sent <= emit_final;
                r_out_vld  <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_count    <= '0;
                r_mark     <= '0;
                r_fin_sent <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_key <= key;
            r_best_idx <= r_cmp_idx;
            r_best_val <= ram_rdata;
        end
        r_cmp_idx <= r_idx;
        if (i_cmd.emit) begin
            r_head     <= emit_cyl;
            r_sum      <= sum_new;
            r_out_cyl  <= emit_cyl;
            r_out_sum  <= sum_new;
            r_out_last <= emit_final;
            if (i_cmd.src == dhss_pkg::SRC_START) begin
                r_h0 <= h0_calc;
            end
        end
    end

    assign o_m_valid = r_out_vld;
    assign o_visit   = r_out_cyl;
    assign o_seek    = r_out_sum;
    assign o_final   = r_out_last;

    assign o_sts.mode     = r_mode;
    assign o_sts.out_free = out_free;
    assign o_sts.idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.found    = r_found;
    assign o_sts.fin_sent = r_fin_sent;

endmodule

### rtl/disk_head_seek_scheduler.sv
// Disk head seek scheduler: FCFS, SSTF, SCAN, C-SCAN, LOOK, C-LOOK visit order.
// Loads one request a cycle; S_START then registers the start visit once output is free.
// FCFS reads each stored entry, then emits it; other modes pick each visit by a pass over
// the store (S_PASS, S_WAIT, S_DECIDE) plus S_PICK, and end with up to three empty passes.
// Input stays held off until the batch ends.
// Reset (synchronous, active low) restores config registers to defaults and empties the store.
module disk_head_seek_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dhss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dhss_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [15:0]                         i_s_axis_tdata,  // [15:0] track
    input  logic                                i_s_axis_tlast,  // batch_end
    // visit stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [dhss_pkg::OUT_W-1:0]          o_m_axis_tdata,  // [15:0] visit_cylinder,
                                                                 // [37:16] seek_total, zero pad
    output logic                                o_m_axis_tlast   // final_res
);
    dhss_pkg::t_cmd             cmd;
    dhss_pkg::t_sts             sts;
    logic [dhss_pkg::CYL_W-1:0] visit;
    logic [dhss_pkg::SUM_W-1:0] seek;

    dhss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    dhss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_track     (i_s_axis_tdata),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_visit     (visit),
        .o_seek      (seek),
        .o_final     (o_m_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // Config writes are always taken
    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {
        (dhss_pkg::OUT_W - dhss_pkg::SUM_W - dhss_pkg::CYL_W)'(0), seek, visit
    };

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for disk_head_seek_scheduler: sends request batches and register writes,
// predicts every head visit in its own model and checks the visit stream field by field.
// Depends on dhss_pkg and the scheduler RTL only.
module tb;

    localparam int DEPTH         = dhss_pkg::MAX_REQUESTS;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_IDLE      = 13;
    localparam int ITEM_TARGET   = 330;

    typedef struct packed {
        logic [15:0] cyl;
        logic [21:0] total;
        logic        fin;
    } t_visit;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [dhss_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [dhss_pkg::CFG_DAT_W-1:0] i_cfg_data;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [15:0]                    i_s_axis_tdata;   // [15:0] track
    logic                           i_s_axis_tlast;   // batch_end
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [dhss_pkg::OUT_W-1:0]     o_m_axis_tdata;   // [15:0] visit_cylinder, [37:16] seek_total
    logic                           o_m_axis_tlast;   // final_res

    // Predictor copy of registers and batch state
    logic [dhss_pkg::MODE_W-1:0] mdl_mode;
    logic [15:0]                 mdl_cyl_count;
    logic [15:0]                 mdl_start;
    logic [15:0]                 req_track [DEPTH];
    bit   [DEPTH-1:0]            served;
    int unsigned                 req_n;
    int unsigned                 head_cyl;
    int unsigned                 seek_sum;

    t_visit pending_visits[$];
    t_visit batch_visits[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned batches_done;
    int unsigned visits_checked;
    bit          calm;   // no idling on either side while set

    disk_head_seek_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- visit order predictor ----------------

    function automatic int unsigned last_cyl();
        return (mdl_cyl_count == 16'd0) ? 0 : int'(mdl_cyl_count) - 1;
    endfunction

    // Move the head, add the travel and record one visit
    function automatic void move_head(int unsigned cyl);
        int unsigned travel;
        t_visit      v;
        travel   = (cyl > head_cyl) ? cyl - head_cyl : head_cyl - cyl;
        seek_sum = (seek_sum + travel) & 32'h003F_FFFF;
        head_cyl = cyl & 32'h0000_FFFF;
        v.cyl    = head_cyl[15:0];
        v.total  = seek_sum[21:0];
        v.fin    = 1'b0;
        batch_visits = {batch_visits, v};
    endfunction

    // Lowest (highest when desc) unserved track in [lo,hi], earliest on ties
    function automatic int take_in_range(int unsigned lo, int unsigned hi, bit desc);
        int best;
        best = -1;
        for (int i = 0; i < int'(req_n); i++) begin
            if (!served[i] && req_track[i] >= lo && req_track[i] <= hi) begin
                if (best < 0 || (desc ? req_track[i] > req_track[best]
                                      : req_track[i] < req_track[best]))
                    best = i;
            end
        end
        if (best >= 0) served[best] = 1'b1;
        return best;
    endfunction

    function automatic void sweep(int unsigned lo, int unsigned hi, bit desc);
        int k;
        k = take_in_range(lo, hi, desc);
        while (k >= 0) begin
            move_head(req_track[k]);
            k = take_in_range(lo, hi, desc);
        end
    endfunction

    // Nearest unserved track to the head, earliest on ties
    function automatic int take_nearest();
        int          best;
        int unsigned best_d;
        int unsigned d;
        best   = -1;
        best_d = 0;
        for (int i = 0; i < int'(req_n); i++) begin
            d = (req_track[i] > head_cyl) ? req_track[i] - head_cyl : head_cyl - req_track[i];
            if (!served[i] && (best < 0 || d < best_d)) begin
                best   = i;
                best_d = d;
            end
        end
        if (best >= 0) served[best] = 1'b1;
        return best;
    endfunction

    // Work out the full visit list of a finished batch
    function automatic void plan_visits();
        int unsigned top;
        int unsigned h0;
        int          k;
        top = last_cyl();
        h0  = (mdl_start > top) ? top : mdl_start;
        batch_visits.delete();
        head_cyl = h0;
        seek_sum = 0;
        move_head(h0);
        case (mdl_mode) inside
            dhss_pkg::MODE_SSTF: begin
                k = take_nearest();
                while (k >= 0) begin
                    move_head(req_track[k]);
                    k = take_nearest();
                end
            end
            dhss_pkg::MODE_SCAN, dhss_pkg::MODE_CSCAN,
            dhss_pkg::MODE_LOOK, dhss_pkg::MODE_CLOOK: begin
                sweep(h0, h0, 1'b0);
                sweep(h0 + 1, 32'h0000_FFFF, 1'b0);
                if (mdl_mode == dhss_pkg::MODE_SCAN || mdl_mode == dhss_pkg::MODE_CSCAN)
                    move_head(top);
                if (mdl_mode == dhss_pkg::MODE_CSCAN) move_head(0);
                if (h0 > 0)
                    sweep(0, h0 - 1,
                          mdl_mode == dhss_pkg::MODE_SCAN || mdl_mode == dhss_pkg::MODE_LOOK);
            end
            default: begin
                for (int i = 0; i < int'(req_n); i++) move_head(req_track[i]);
            end
        endcase
        batch_visits[batch_visits.size() - 1].fin = 1'b1;
        pending_visits = {pending_visits, batch_visits};
        served = '0;
        req_n  = 0;
    endfunction

    // Accepted request: saturate, store unless full, schedule on batch end
    function automatic void load_request(logic [15:0] track, logic end_flag);
        int unsigned top;
        int unsigned t;
        top = last_cyl();
        t   = (track > top) ? top : track;
        if (req_n < DEPTH) begin
            req_track[req_n] = t[15:0];
            served[req_n]    = 1'b0;
            req_n++;
        end
        if (end_flag) plan_visits();
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : visit_check
        t_visit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_visits.size() == 0) begin
                report_mismatch("visit with none pending", 0, o_m_axis_tdata[15:0]);
            end else begin
                want = pending_visits.pop_front();
                visits_checked++;
                if (o_m_axis_tdata[15:0] !== want.cyl)
                    report_mismatch("visit cylinder", want.cyl, o_m_axis_tdata[15:0]);
                if (o_m_axis_tdata[37:16] !== want.total)
                    report_mismatch("seek total", want.total, o_m_axis_tdata[37:16]);
                if (o_m_axis_tlast !== want.fin)
                    report_mismatch("final flag", want.fin, o_m_axis_tlast);
            end
        end
    end

    // Visit sink: random stall before each transfer
    initial begin : visit_sink
        int unsigned hold;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
            repeat (hold) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(o_m_axis_tvalid && i_m_axis_tready)) @(posedge i_clk);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic write_reg(input logic [dhss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dhss_pkg::CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        case (idx)
            dhss_pkg::CFG_MODE:      mdl_mode      = value[dhss_pkg::MODE_W-1:0];
            dhss_pkg::CFG_CYL_COUNT: mdl_cyl_count = value;
            dhss_pkg::CFG_START:     mdl_start     = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One request transfer after a random gap; valid stays up until the next call
    task automatic send_request(input logic [15:0] track, input logic end_flag);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= track;
        i_s_axis_tlast  <= end_flag;
        @(posedge i_clk);
        while (!(i_s_axis_tvalid && o_s_axis_tready)) @(posedge i_clk);
        items_sent++;
        load_request(track, end_flag);
    endtask

    // Send a whole batch, then wait for its visits and let the block settle
    task automatic run_batch(input logic [15:0] tracks[$]);
        foreach (tracks[i]) send_request(tracks[i], i == tracks.size() - 1);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        batches_done++;
    endtask

    // ---------------- tests ----------------

    // Reset settings: FCFS, 200 cylinders, start 0; includes saturated tracks
    task automatic test_reset_defaults();
        run_batch({16'd0, 16'd65535, 16'd199});
    endtask

    // Every policy but FCFS on one batch with a request on the start cylinder and an SSTF tie
    task automatic test_each_policy();
        write_reg(dhss_pkg::CFG_START, 16'd100);
        for (int m = dhss_pkg::MODE_SSTF; m <= dhss_pkg::MODE_CLOOK; m++) begin
            write_reg(dhss_pkg::CFG_MODE, 16'(m));
            run_batch({16'd130, 16'd100, 16'd70});
        end
    endtask

    // Unknown mode, tiny disks, start beyond the disk, the largest disk
    task automatic test_odd_settings();
        write_reg(dhss_pkg::CFG_MODE, 16'd6);
        run_batch({16'd70, 16'd30});
        write_reg(dhss_pkg::CFG_MODE, 16'(dhss_pkg::MODE_SCAN));
        write_reg(dhss_pkg::CFG_CYL_COUNT, 16'd1);
        write_reg(dhss_pkg::CFG_START, 16'd0);
        run_batch({16'd5});
        write_reg(dhss_pkg::CFG_MODE, 16'(dhss_pkg::MODE_CSCAN));
        write_reg(dhss_pkg::CFG_CYL_COUNT, 16'd0);
        run_batch({16'd9});
        write_reg(dhss_pkg::CFG_MODE, 16'(dhss_pkg::MODE_LOOK));
        write_reg(dhss_pkg::CFG_CYL_COUNT, 16'd50);
        write_reg(dhss_pkg::CFG_START, 16'd300);
        run_batch({16'd49, 16'd10});
        write_reg(dhss_pkg::CFG_MODE, 16'(dhss_pkg::MODE_CSCAN));
        write_reg(dhss_pkg::CFG_CYL_COUNT, 16'd65535);
        write_reg(dhss_pkg::CFG_START, 16'd65534);
        run_batch({16'd0, 16'd65535});
    endtask

    // Random settings and batches; mostly small disks so ties and repeats are common
    task automatic test_random_batches(input int unsigned target);
        int unsigned cyl;
        int unsigned top;
        int unsigned start;
        int unsigned n;
        logic [15:0] batch[$];
        while (items_sent < target) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                write_reg(dhss_pkg::CFG_MODE, 16'($urandom_range(0, 7)));
            case ($urandom_range(0, 9)) inside
                0:       cyl = 2;
                1:       cyl = 65535;
                2:       cyl = $urandom_range(0, 1);
                3, 4:    cyl = $urandom_range(2, 65535);
                default: cyl = $urandom_range(2, 40);
            endcase
            top = (cyl > 1) ? cyl - 1 : 0;
            case ($urandom_range(0, 7))
                0:       start = 0;
                1:       start = top;
                2:       start = $urandom_range(0, 65535);
                3:       start = 65534;
                default: start = $urandom_range(0, top);
            endcase
            write_reg(dhss_pkg::CFG_CYL_COUNT, 16'(cyl));
            write_reg(dhss_pkg::CFG_START, 16'(start));
            // occasionally overfill the store
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
            batch.delete();
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0:       batch = {batch, 16'($urandom)};
                    1:       batch = {batch, 16'(start)};
                    default: batch = {batch, 16'($urandom_range(0, top))};
                endcase
            end
            run_batch(batch);
        end
        calm = 1'b0;
    endtask

    // ---------------- run ----------------

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        mdl_mode        = dhss_pkg::RST_MODE;
        mdl_cyl_count   = dhss_pkg::RST_CYL_COUNT;
        mdl_start       = dhss_pkg::RST_START;
        served          = '0;
        req_n           = 0;
        head_cyl        = 0;
        seek_sum        = 0;
        errors          = 0;
        items_sent      = 0;
        batches_done    = 0;
        visits_checked  = 0;
        calm            = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_each_policy();
        test_odd_settings();
        test_random_batches(ITEM_TARGET);

        $display("Ran %0d batches (%0d requests) through all mode codes, disk sizes 0 to 65535;",
                 batches_done, items_sent);
        $display("%0d visits checked, %0d mismatches.", visits_checked, errors);
        if (errors == 0 && pending_visits.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Timeout with %0d visits still pending", pending_visits.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
